[src/snit_pkg.sv]
`timescale 1ns / 1ps

package snit_pkg;

  localparam int DEPTH      = 16;
  localparam int NAME_BYTES = 40;
  localparam int NAME_WORDS = 5;
  localparam int WORD_W     = 64;
  localparam int NAME_W     = NAME_WORDS * WORD_W;
  localparam int POS_W      = 6;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef logic [NAME_W-1:0] name_t;  // word 0 in the top bits

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LIST   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_CLEARED = 2'd3
  } stat_e;

  // Per-cell control broadcast from the sequencer.
  typedef struct packed {
    logic insert;  // open a slot at the boundary and shift the tail down
    logic rotate;  // move every entry one place toward cell 0
  } cell_ctrl_t;

  // Keeps the leading bytes of word w that lie below NAME_BYTES.
  function automatic logic [WORD_W-1:0] word_mask(input int w);
    int k;
    logic [WORD_W-1:0] m;
    k = NAME_BYTES - 8 * w;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (b < k) begin
        m[WORD_W-1-8*b -: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  function automatic name_t name_mask();
    name_t m;
    m = '0;
    for (int w = 0; w < NAME_WORDS; w++) begin
      m[NAME_W-1-WORD_W*w -: WORD_W] = word_mask(w);
    end
    return m;
  endfunction

  localparam name_t NAME_MASK = name_mask();

endpackage

[src/snit_cell.sv]
`timescale 1ns / 1ps

module snit_cell
  import snit_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occupied_i,   // this cell holds a live entry
  input  logic       wrap_i,       // last live cell: takes the head on rotate
  input  logic       prev_lt_i,    // upper neighbor is smaller than the new word
  input  name_t      new_name_i,
  input  name_t      prev_name_i,
  input  name_t      next_name_i,
  input  name_t      head_name_i,
  output name_t      name_o,
  output logic       lt_o
);

  name_t name_q, name_d;

  assign lt_o   = occupied_i && (name_q < new_name_i);
  assign name_o = name_q;

  always_comb begin
    name_d = name_q;
    if (ctrl_i.insert && !lt_o) begin
      name_d = prev_lt_i ? new_name_i : prev_name_i;
    end else if (ctrl_i.rotate) begin
      name_d = wrap_i ? head_name_i : next_name_i;
    end
  end

  always_ff @(posedge clk_i) begin
    name_q <= name_d;
  end

endmodule

[src/sorted_name_insertion_table_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// command   in         start_i / busy_o   command_i, name_word_0_i .. name_word_4_i
// result    out        valid_o strobe     status_o, position_o, out_word_0_o .. 4, last_o
//
// For insert, clear and an empty list, the word is accepted and its
// result shows on the next cycle; a new command may follow at once.
// A list of N names holds busy_o while it gives N results, one result per cycle, set by the
// entry chain rotating one place per cycle toward cell 0.
// Reset empties the table; stored names are not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.

module sorted_name_insertion_table_core
  import snit_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        command_i,
  input  logic [WORD_W-1:0] name_word_0_i,
  input  logic [WORD_W-1:0] name_word_1_i,
  input  logic [WORD_W-1:0] name_word_2_i,
  input  logic [WORD_W-1:0] name_word_3_i,
  input  logic [WORD_W-1:0] name_word_4_i,
  output logic              valid_o,
  output logic [1:0]        status_o,
  output logic [POS_W-1:0]  position_o,
  output logic [WORD_W-1:0] out_word_0_o,
  output logic [WORD_W-1:0] out_word_1_o,
  output logic [WORD_W-1:0] out_word_2_o,
  output logic [WORD_W-1:0] out_word_3_o,
  output logic [WORD_W-1:0] out_word_4_o,
  output logic              last_o
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // Sequencer state
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             listing_q, listing_d;
  logic             valid_q, valid_d;

  // Result word
  stat_e            status_q, status_d;
  logic [POS_W-1:0] pos_q, pos_d;
  name_t            out_name_q, out_name_d;
  logic             last_q, last_d;

  logic       accept;
  cmd_e       cmd;
  name_t      name_in;
  logic       full;
  cell_ctrl_t ctrl;

  name_t            cell_name [DEPTH];
  name_t            prev_name [DEPTH];
  name_t            next_name [DEPTH];
  logic [DEPTH-1:0] lt, prev_lt, occupied, wrap;
  logic [POS_W-1:0] ins_pos;
  logic             list_last;

  assign accept  = start_i && !listing_q;
  assign cmd     = cmd_e'(command_i);
  assign name_in = {name_word_0_i, name_word_1_i, name_word_2_i,
                    name_word_3_i, name_word_4_i} & NAME_MASK;
  assign full    = (count_q == FULL_CNT);

  assign ctrl.insert = accept && (cmd == CMD_INSERT) && !full;
  assign ctrl.rotate = listing_q;

  // Neighbor wiring: cell 0 sees "all above smaller" so it takes the new
  // name unless it is itself smaller.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occupied[i]  = (CNT_W'(i) < count_q);
      wrap[i]      = (CNT_W'(i + 1) == count_q);
      prev_lt[i]   = (i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i - 1];
      prev_name[i] = (i == 0) ? name_in : cell_name[(i == 0) ? 0 : i - 1];
      next_name[i] = (i == DEPTH - 1) ? cell_name[i]
                                      : cell_name[(i == DEPTH - 1) ? i : i + 1];
    end
  end

  // Insertion point: the single cell that is not smaller while its upper
  // neighbor is.
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!lt[i] && prev_lt[i]) begin
        ins_pos = ins_pos | POS_W'(i);
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    snit_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (occupied[g]),
      .wrap_i      (wrap[g]),
      .prev_lt_i   (prev_lt[g]),
      .new_name_i  (name_in),
      .prev_name_i (prev_name[g]),
      .next_name_i (next_name[g]),
      .head_name_i (cell_name[0]),
      .name_o      (cell_name[g]),
      .lt_o        (lt[g])
    );
  end

  assign list_last = (idx_q + CNT_W'(1) == count_q);

  always_comb begin
    count_d    = count_q;
    idx_d      = idx_q;
    listing_d  = listing_q;
    valid_d    = 1'b0;
    status_d   = STAT_OK;
    pos_d      = '0;
    out_name_d = '0;
    last_d     = 1'b1;
    if (accept) begin
      case (cmd)
        CMD_INSERT: begin
          valid_d = 1'b1;
          if (full) begin
            status_d = STAT_FULL;
          end else begin
            pos_d   = ins_pos;
            count_d = count_q + CNT_W'(1);
          end
        end
        CMD_LIST: begin
          if (count_q == '0) begin
            valid_d  = 1'b1;
            status_d = STAT_EMPTY;
          end else begin
            listing_d = 1'b1;
            idx_d     = '0;
          end
        end
        CMD_CLEAR: begin
          valid_d  = 1'b1;
          status_d = STAT_CLEARED;
          count_d  = '0;
        end
        default: begin
          valid_d = 1'b0;
        end
      endcase
    end else if (listing_q) begin
      // Cell 0 holds entry idx; the chain rotates it to the tail.
      valid_d    = 1'b1;
      pos_d      = POS_W'(idx_q);
      out_name_d = cell_name[0];
      last_d     = list_last;
      idx_d      = idx_q + CNT_W'(1);
      if (list_last) begin
        listing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      idx_q     <= '0;
      listing_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      count_q   <= count_d;
      idx_q     <= idx_d;
      listing_q <= listing_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    pos_q      <= pos_d;
    out_name_q <= out_name_d;
    last_q     <= last_d;
  end

  assign busy_o       = listing_q;
  assign valid_o      = valid_q;
  assign status_o     = status_q;
  assign position_o   = pos_q;
  assign out_word_0_o = out_name_q[NAME_W-1 -: WORD_W];
  assign out_word_1_o = out_name_q[NAME_W-1-WORD_W -: WORD_W];
  assign out_word_2_o = out_name_q[NAME_W-1-2*WORD_W -: WORD_W];
  assign out_word_3_o = out_name_q[NAME_W-1-3*WORD_W -: WORD_W];
  assign out_word_4_o = out_name_q[NAME_W-1-4*WORD_W -: WORD_W];
  assign last_o       = last_q;

endmodule
